/* rtl/mexp_pkg.sv */
package mexp_pkg;

  localparam int unsigned BASE_W   = 30;
  localparam int unsigned EXP_W    = 63;
  localparam int unsigned POWER_W  = 30;
  localparam int unsigned EXP_BITS_DEFAULT = 63;

  // Prime modulus and Barrett constant floor(2^60 / p)
  localparam logic [29:0] MODULUS  = 30'd1000000007;
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  localparam int unsigned OPND_W = 31;
  localparam int unsigned PROD_W = 2 * OPND_W;

  localparam int unsigned UPC_W   = 3;
  localparam logic [UPC_W-1:0] UC_LAST = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    OPA_ACC = 2'd0,
    OPA_SQ  = 2'd1,
    OPA_Q1  = 2'd2,
    OPA_Q3  = 2'd3
  } opa_e;

  typedef enum logic [1:0] {
    OPB_SQ  = 2'd0,
    OPB_MU  = 2'd1,
    OPB_MOD = 2'd2
  } opb_e;

  // One microcode word
  typedef struct packed {
    logic mul_en;    // multiplier result is written this step
    opa_e opa;
    opb_e opb;
    logic dst_sq;    // product goes to the squaring path, else multiply path
    logic load_x;    // capture low product bits for the final subtract
    logic wr_acc;    // correct and write accumulator (if exponent bit set)
    logic wr_sq;     // correct and write running square
    logic loop_end;  // shift exponent, branch back or finish
  } uc_word_t;

  // Per exponent bit: two interleaved Barrett products, then corrections.
  function automatic uc_word_t uc_fetch(input logic [UPC_W-1:0] upc);
    uc_word_t w;
    w = '0;
    unique case (upc)
      3'd0: begin
        w.mul_en = 1'b1; w.opa = OPA_ACC; w.opb = OPB_SQ;  w.load_x = 1'b1;
      end
      3'd1: begin
        w.mul_en = 1'b1; w.opa = OPA_SQ;  w.opb = OPB_SQ;  w.dst_sq = 1'b1;
        w.load_x = 1'b1;
      end
      3'd2: begin
        w.mul_en = 1'b1; w.opa = OPA_Q1;  w.opb = OPB_MU;
      end
      3'd3: begin
        w.mul_en = 1'b1; w.opa = OPA_Q1;  w.opb = OPB_MU;  w.dst_sq = 1'b1;
      end
      3'd4: begin
        w.mul_en = 1'b1; w.opa = OPA_Q3;  w.opb = OPB_MOD;
      end
      3'd5: begin
        w.mul_en = 1'b1; w.opa = OPA_Q3;  w.opb = OPB_MOD; w.dst_sq = 1'b1;
        w.wr_acc = 1'b1;
      end
      3'd6: begin
        w.wr_sq = 1'b1; w.loop_end = 1'b1;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/modular_exponentiation_top.sv */
// Channel | Direction | Handshake                 | Beat contents
// in      | sink      | in_valid_i / in_stall_o   | base_i[29:0], exponent_i[62:0]
// out     | source    | out_valid_o / out_stall_i | power_o[29:0]
//
// Flow: load, then the microcode steps for each exponent bit up to the highest set bit
//   (bits at EXP_BITS and above ignored), then the output register; a zero exponent
//   skips the loop. The 7 steps are six multiplies on the one shared 31x31
//   multiplier (three Barrett steps per modular product) and a last correction.
// Reset: asynchronous, active low; clears sequencer and output valid only.
// Stalls: one item in flight; a new beat is taken once the result is registered, stalled or not.
module modular_exponentiation_top #(
  parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mexp_pkg::BASE_W-1:0]    base_i,
  input  logic [mexp_pkg::EXP_W-1:0]     exponent_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mexp_pkg::POWER_W-1:0]   power_o
);
  import mexp_pkg::*;

  // Sequencer state
  state_e             state_q, state_d;
  logic [UPC_W-1:0]   upc_q, upc_d;
  uc_word_t           uc;

  // Datapath
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [29:0]         acc_q, acc_d;    // accumulator, always below p
  logic [29:0]         sq_q, sq_d;      // running square, always below p
  logic [PROD_W-1:0]   pa_q, pa_d;      // product register, multiply path
  logic [PROD_W-1:0]   ps_q, ps_d;      // product register, square path
  logic [31:0]         xa_q, xa_d;      // low bits of full product, multiply path
  logic [31:0]         xs_q, xs_d;      // low bits of full product, square path

  logic                out_valid_q, out_valid_d;
  logic [29:0]         power_q, power_d;

  logic                in_acc;
  logic                out_free;
  logic [63:0]         exp_ext;
  logic [EXP_BITS-1:0] exp_load;
  logic [EXP_BITS-1:0] exp_shift;
  logic [29:0]         base_red;
  logic [30:0]         base_m1;

  logic [PROD_W-1:0]   p_path;
  logic [OPND_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]   prod;

  logic [31:0]         corr_x, corr_r;
  logic [32:0]         corr_m1, corr_m2;
  logic [29:0]         corr_out;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign power_o     = power_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign uc = uc_fetch(upc_q);

  // Exponent masked to the datapath width on load
  assign exp_ext   = {1'b0, exponent_i};
  assign exp_load  = exp_ext[EXP_BITS-1:0];
  assign exp_shift = exp_q >> 1;

  // Base is below 2^30 < 2p, so one compare-subtract reduces it
  assign base_m1  = {1'b0, base_i} - {1'b0, MODULUS};
  assign base_red = base_m1[30] ? base_i : base_m1[29:0];

  // Shared multiplier; Barrett operands are taken from the addressed path
  assign p_path = uc.dst_sq ? ps_q : pa_q;

  always_comb begin
    unique case (uc.opa)
      OPA_ACC: mul_a = {1'b0, acc_q};
      OPA_SQ:  mul_a = {1'b0, sq_q};
      OPA_Q1:  mul_a = p_path[59:29];   // x >> (k-1)
      OPA_Q3:  mul_a = p_path[61:31];   // (q1 * mu) >> (k+1)
      default: mul_a = '0;
    endcase
    unique case (uc.opb)
      OPB_SQ:  mul_b = {1'b0, sq_q};
      OPB_MU:  mul_b = BARRETT_MU;
      OPB_MOD: mul_b = {1'b0, MODULUS};
      default: mul_b = '0;
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Barrett correction: r = x - q3*p lies below 3p, two trial subtracts
  assign corr_x   = uc.wr_sq ? xs_q : xa_q;
  assign corr_r   = corr_x - (uc.wr_sq ? ps_q[31:0] : pa_q[31:0]);
  assign corr_m1  = {1'b0, corr_r} - {3'b000, MODULUS};
  assign corr_m2  = {1'b0, corr_r} - {2'b00, MODULUS, 1'b0};

  always_comb begin
    if (!corr_m2[32]) begin
      corr_out = corr_m2[29:0];
    end else if (!corr_m1[32]) begin
      corr_out = corr_m1[29:0];
    end else begin
      corr_out = corr_r[29:0];
    end
  end

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    upc_d       = upc_q;
    exp_d       = exp_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    pa_d        = pa_q;
    ps_d        = ps_q;
    xa_d        = xa_q;
    xs_d        = xs_q;
    out_valid_d = out_valid_q && out_stall_i;
    power_d     = power_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          acc_d   = 30'd1;
          sq_d    = base_red;
          exp_d   = exp_load;
          upc_d   = '0;
          state_d = (exp_load == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (uc.mul_en) begin
          if (uc.dst_sq) begin
            ps_d = prod;
          end else begin
            pa_d = prod;
          end
        end
        if (uc.load_x) begin
          if (uc.dst_sq) begin
            xs_d = prod[31:0];
          end else begin
            xa_d = prod[31:0];
          end
        end
        if (uc.wr_acc && exp_q[0]) begin
          acc_d = corr_out;
        end
        if (uc.wr_sq) begin
          sq_d = corr_out;
        end
        if (uc.loop_end) begin
          exp_d = exp_shift;
          upc_d = '0;
          if (exp_shift == '0) begin
            state_d = ST_DONE;
          end
        end else begin
          upc_d = upc_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          power_d     = acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q   <= exp_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    pa_q    <= pa_d;
    ps_q    <= ps_d;
    xa_q    <= xa_d;
    xs_q    <= xs_d;
    power_q <= power_d;
  end

  // Microcode never runs past the last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> upc_q <= UC_LAST)
    else $error("micro-PC beyond program");

  // Running square stays reduced through the loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> sq_q < MODULUS)
    else $error("running square not reduced");

  // Accumulator is reduced when the result is handed over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> acc_q < MODULUS)
    else $error("accumulator not reduced");

  // An accepted beat always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted beat dropped");

  // A result is only launched from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result without completed run");

endmodule
